[rtl/dmx_to_mpx_converter_core_macros.svh]
// ---------------------------------------------------------------------------
// DMX to MPX converter assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ---------------------------------------------------------------------------
`ifndef DMX_TO_MPX_CONVERTER_CORE_MACROS_SVH
`define DMX_TO_MPX_CONVERTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// checked outside reset
`define DMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DMC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DMC_ASSERT(lbl, prop, msg)
`define DMC_ASSERT_RST(lbl, prop, msg)

`endif

`endif

[rtl/dmc_pkg.sv]
// ---------------------------------------------------------------------------
// DMX to MPX converter package
// Word types and the item classification shared by front and back.
// ---------------------------------------------------------------------------
package dmc_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	typedef struct packed {
		logic [2:0] mode;
		logic       line_level;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic        dac_valid;
		logic [9:0]  dac_code;
		logic [15:0] next_period;
		logic        receiving;
		logic        activity;
	} result_t;

	typedef enum logic [2:0] {
		OP_SAMPLE,
		OP_BYTE,
		OP_TICK,
		OP_OVERRUN,
		OP_ERROR,
		OP_NONE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       level;
		logic [7:0] data;
	} entry_t;

endpackage

[rtl/dmx_to_mpx_converter_core.sv]
// ---------------------------------------------------------------------------
// DMX to MPX converter core
// DMX512 break hunt and slot capture feeding an MPX channel sequencer.
// ---------------------------------------------------------------------------
//  channel  handshake              payload
//  item     item_valid/item_ready  item_word (mode, line_level, rx_byte)
//  result   res_valid/res_ready    res_word (dac_valid .. activity)
//  config   cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  One word per cycle sustained while results are taken; a word passes through
//  the queue slot, then execute into the result register alongside the slot
//  RAM's registered read, and its result is valid once it reaches that register.
//  Reset clears all control state and the slot valid bits; no clearing pass.
//  A held result stalls execution only; the queue keeps taking words until it
//  holds two.
//  cfg_ready is always high.
// ---------------------------------------------------------------------------
module dmx_to_mpx_converter_core import dmc_pkg::*; #(
	parameter int OUT_CHANNELS  = 16,
	parameter int CAPTURE_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item_word,
	output logic                  res_valid,
	input  logic                  res_ready,
	output result_t               res_word,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic   q_valid;
	entry_t q_entry;
	logic   q_pop;

	assign cfg_ready = 1'b1;

	dmc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item_word  (item_word),
		.q_valid    (q_valid),
		.q_entry    (q_entry),
		.q_pop      (q_pop)
	);

	dmc_back #(
		.OUT_CHANNELS  (OUT_CHANNELS),
		.CAPTURE_DEPTH (CAPTURE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (q_entry),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule

[rtl/dmc_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ---------------------------------------------------------------------------
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/dmc_front.sv]
// ---------------------------------------------------------------------------
// DMX to MPX converter front end
// Accepts input words, decodes the mode and queues them two deep.
// ---------------------------------------------------------------------------
`include "dmx_to_mpx_converter_core_macros.svh"

module dmc_front import dmc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   item_valid,
	output logic   item_ready,
	input  item_t  item_word,
	output logic   q_valid,
	output entry_t q_entry,
	input  logic   q_pop
);

	localparam logic [2:0] MODE_SAMPLE  = 3'd0;
	localparam logic [2:0] MODE_BYTE    = 3'd1;
	localparam logic [2:0] MODE_TICK    = 3'd2;
	localparam logic [2:0] MODE_OVERRUN = 3'd3;
	localparam logic [2:0] MODE_ERROR   = 3'd4;

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	entry_t     dec;
	logic       push;

	always_comb begin
		dec.level = item_word.line_level;
		dec.data  = item_word.rx_byte;
		unique case (item_word.mode)
			MODE_SAMPLE:  dec.op = OP_SAMPLE;
			MODE_BYTE:    dec.op = OP_BYTE;
			MODE_TICK:    dec.op = OP_TICK;
			MODE_OVERRUN: dec.op = OP_OVERRUN;
			MODE_ERROR:   dec.op = OP_ERROR;
			default:      dec.op = OP_NONE;
		endcase
	end

	assign item_ready = (cnt_q != 2'd2);
	assign push       = item_valid && item_ready;
	assign q_valid    = (cnt_q != 2'd0);
	assign q_entry    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= dec;
		end
	end

	`DMC_ASSERT_RST(a_cnt_bound, cnt_q <= 2'd2, "queue count overflow")
	`DMC_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")
	`DMC_ASSERT(a_push_count, (push && !q_pop) |=> cnt_q == $past(cnt_q) + 2'd1, "count lost a push")

endmodule

[rtl/dmc_back.sv]
// ---------------------------------------------------------------------------
// DMX to MPX converter back end
// Runs the break hunter, slot capture and MPX sequencer, one word a cycle unless a held result stalls it.
// ---------------------------------------------------------------------------
`include "dmx_to_mpx_converter_core_macros.svh"

module dmc_back import dmc_pkg::*; #(
	parameter int OUT_CHANNELS  = 16,
	parameter int CAPTURE_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  q_valid,
	input  entry_t                q_entry,
	output logic                  q_pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output result_t               res_word
);

	localparam int BUF_N = CAPTURE_DEPTH + 1;
	localparam int AW    = $clog2(BUF_N);
	localparam int IDX_W = $clog2(BUF_N + 1);
	localparam int CH_W  = $clog2(OUT_CHANNELS + 1);
	localparam int VN    = (OUT_CHANNELS < BUF_N) ? OUT_CHANNELS : BUF_N;

	localparam logic [CFG_IDX_W-1:0] CFG_START_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BREAK      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG       = 2'd3;

	localparam logic [1:0] RX_HUNT  = 2'd0;
	localparam logic [1:0] RX_BREAK = 2'd1;
	localparam logic [1:0] RX_RECV  = 2'd2;

	localparam logic [1:0] MPX_FIRST = 2'd0;
	localparam logic [1:0] MPX_SHORT = 2'd1;
	localparam logic [1:0] MPX_NEXT  = 2'd2;
	localparam logic [1:0] MPX_LONG  = 2'd3;

	localparam logic [9:0]  DAC_SYNC   = 10'd0;
	localparam logic [9:0]  DAC_MID    = 10'd512;
	localparam logic [15:0] PERIOD_RST = 16'd11000;

	logic [9:0]       start_addr_q;
	logic [7:0]       brk_q;
	logic [15:0]      short_q;
	logic [15:0]      long_q;

	logic [1:0]       rx_phase_q, rx_phase_d;
	logic [7:0]       low_run_q, low_run_d;
	logic [9:0]       byte_count_q, byte_count_d;
	logic [IDX_W-1:0] store_idx_q, store_idx_d;
	logic [VN-1:0]    vbit_q;
	logic [1:0]       mpx_phase_q, mpx_phase_d;
	logic [CH_W-1:0]  mpx_ch_q, mpx_ch_d;
	logic [15:0]      period_q, period_d;
	logic             activity_q, activity_d;

	logic             res_valid_s2;
	logic             dac_valid_s2;
	logic             chan_s2;
	logic             hit_s2;

	logic             fire;
	logic             tick;
	logic             chan;
	logic             hit;
	logic             vhit;
	logic             store;
	logic             wr_en;
	logic             rd_en;
	logic [7:0]       lr_inc;
	logic [9:0]       bc_inc;
	logic [IDX_W-1:0] si_inc;
	logic [CH_W-1:0]  ch_idx;
	logic [7:0]       rd_data;

	assign fire  = q_valid && (!res_valid_s2 || res_ready);
	assign q_pop = fire;

	assign lr_inc = (low_run_q == 8'hFF) ? low_run_q : low_run_q + 8'd1;
	assign bc_inc = (byte_count_q == 10'h3FF) ? byte_count_q : byte_count_q + 10'd1;
	assign si_inc = store_idx_q + IDX_W'(1);
	assign ch_idx = mpx_ch_q - CH_W'(1);

	always_comb begin
		vhit = 1'b0;
		for (int i = 0; i < VN; i++) begin
			if (ch_idx == CH_W'(i)) begin
				vhit = vbit_q[i];
			end
		end
	end

	always_comb begin
		rx_phase_d   = rx_phase_q;
		low_run_d    = low_run_q;
		byte_count_d = byte_count_q;
		store_idx_d  = store_idx_q;
		mpx_phase_d  = mpx_phase_q;
		mpx_ch_d     = mpx_ch_q;
		period_d     = period_q;
		activity_d   = activity_q;
		tick         = 1'b0;
		chan         = 1'b0;
		hit          = 1'b0;
		store        = 1'b0;
		unique case (q_entry.op)
			OP_SAMPLE: begin
				if (rx_phase_q != RX_RECV) begin
					if (q_entry.level) begin
						if (rx_phase_q == RX_BREAK) begin
							rx_phase_d = RX_RECV;
						end else begin
							low_run_d = 8'd0;
						end
					end else begin
						low_run_d = lr_inc;
						if (lr_inc >= brk_q) begin
							rx_phase_d = RX_BREAK;
						end
					end
				end
			end
			OP_BYTE: begin
				if (rx_phase_q == RX_RECV) begin
					byte_count_d = bc_inc;
					if (bc_inc > start_addr_q) begin
						store       = 1'b1;
						activity_d  = 1'b1;
						store_idx_d = si_inc;
						if (si_inc >= IDX_W'(BUF_N)) begin
							rx_phase_d   = RX_HUNT;
							low_run_d    = 8'd0;
							byte_count_d = 10'd0;
							store_idx_d  = '0;
						end
					end
				end
			end
			OP_TICK: begin
				tick = 1'b1;
				unique case (mpx_phase_q) inside
					MPX_FIRST, MPX_NEXT: begin
						if (mpx_phase_q == MPX_FIRST) begin
							period_d = short_q;
						end
						chan = 1'b1;
						hit  = vhit;
						if (mpx_ch_q >= CH_W'(OUT_CHANNELS)) begin
							mpx_ch_d    = CH_W'(1);
							mpx_phase_d = MPX_LONG;
						end else begin
							mpx_ch_d    = mpx_ch_q + CH_W'(1);
							mpx_phase_d = MPX_SHORT;
						end
					end
					MPX_SHORT: begin
						mpx_phase_d = MPX_NEXT;
					end
					MPX_LONG: begin
						period_d    = long_q;
						mpx_phase_d = MPX_FIRST;
					end
				endcase
			end
			OP_OVERRUN: begin
				if (rx_phase_q == RX_RECV) begin
					rx_phase_d   = RX_HUNT;
					low_run_d    = 8'd0;
					byte_count_d = 10'd0;
					store_idx_d  = '0;
				end
			end
			OP_ERROR: begin
				if (rx_phase_q == RX_RECV) begin
					activity_d = 1'b0;
				end
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign wr_en = fire && store && (store_idx_q < IDX_W'(BUF_N));
	assign rd_en = fire && chan;

	dmc_ram #(
		.WIDTH (8),
		.DEPTH (BUF_N)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (AW'(store_idx_q)),
		.wr_data (q_entry.data),
		.rd_en   (rd_en),
		.rd_addr (AW'(ch_idx)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_addr_q <= 10'd1;
			brk_q        <= 8'd20;
			short_q      <= 16'd1000;
			long_q       <= 16'd22000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_START_ADDR: start_addr_q <= cfg_data[9:0];
				CFG_BREAK:      brk_q        <= cfg_data[7:0];
				CFG_SHORT:      short_q      <= cfg_data;
				CFG_LONG:       long_q       <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q   <= RX_HUNT;
			low_run_q    <= 8'd0;
			byte_count_q <= 10'd0;
			store_idx_q  <= '0;
			vbit_q       <= '0;
			mpx_phase_q  <= MPX_FIRST;
			mpx_ch_q     <= CH_W'(1);
			period_q     <= PERIOD_RST;
			activity_q   <= 1'b0;
			res_valid_s2 <= 1'b0;
		end else begin
			if (fire) begin
				rx_phase_q   <= rx_phase_d;
				low_run_q    <= low_run_d;
				byte_count_q <= byte_count_d;
				store_idx_q  <= store_idx_d;
				mpx_phase_q  <= mpx_phase_d;
				mpx_ch_q     <= mpx_ch_d;
				period_q     <= period_d;
				activity_q   <= activity_d;
				for (int i = 0; i < VN; i++) begin
					if (wr_en && store_idx_q == IDX_W'(i)) begin
						vbit_q[i] <= 1'b1;
					end
				end
			end
			if (fire) begin
				res_valid_s2 <= 1'b1;
			end else if (res_ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			dac_valid_s2 <= tick;
			chan_s2      <= chan;
			hit_s2       <= hit;
		end
	end

	// state registers only move on fire, so they hold the post-state of the shown word
	always_comb begin
		res_word.dac_valid   = dac_valid_s2;
		res_word.dac_code    = !chan_s2 ? DAC_SYNC : hit_s2 ? {1'b1, rd_data, 1'b0} : DAC_MID;
		res_word.next_period = period_q;
		res_word.receiving   = (rx_phase_q == RX_RECV);
		res_word.activity    = activity_q;
	end

	assign res_valid = res_valid_s2;

	`DMC_ASSERT_RST(a_store_bound, store_idx_q < IDX_W'(BUF_N), "store index past buffer")
	`DMC_ASSERT(a_tick_result, (fire && q_entry.op == OP_TICK) |=> (res_valid_s2 && dac_valid_s2), "tick lost")
	`DMC_ASSERT(a_stall_hold, (res_valid_s2 && !res_ready) |=> ($stable(period_q) && $stable(mpx_ch_q) && $stable(store_idx_q)), "state moved under stall")
	`DMC_ASSERT(a_sync_next, (fire && q_entry.op == OP_TICK && mpx_phase_q == MPX_SHORT) |=> (mpx_phase_q == MPX_NEXT), "short sync not followed by channel")

endmodule
